/* rtl/core/oal_pkg.sv */
// Shared types and codes for the ordered array list engine.
// No dependencies; compiled first.
package oal_pkg;

	localparam int MODE_W = 2;
	localparam int POS_W  = 7;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;

	localparam logic [MODE_W-1:0] OP_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] OP_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] OP_LOCATE = 2'd2;
	localparam logic [MODE_W-1:0] OP_GET    = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] data_out;
		logic [POS_W-1:0]         found_position;
		logic [POS_W-1:0]         count;
		logic                     is_empty;
	} oal_result_t;

endpackage

/* rtl/core/oal_if.sv */
// Request and response channel interfaces (valid/ready beats).
// Field widths follow oal_pkg.
interface oal_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [6:0]         position;
	logic signed [31:0] value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink (input valid, input mode, input position, input value, output ready);
endinterface

interface oal_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] data_out;
	logic [6:0]         found_position;
	logic [6:0]         count;
	logic               is_empty;

	modport source (output valid, output status, output data_out, output found_position,
		output count, output is_empty, input ready);
	modport sink (input valid, input status, input data_out, input found_position,
		input count, input is_empty, output ready);
endinterface

/* rtl/core/oal_mem.sv */
// Entry store: one write port, one read port, registered read data.
// Depends on nothing; instantiated by the top level.
module oal_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/oal_ctrl.sv */
// Sequencer: checks requests, walks the entry store for shifts and searches.
// Depends on oal_pkg; drives oal_mem ports.
module oal_ctrl #(
	parameter int CAPACITY = 64,
	parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_mode,
	input  logic [6:0]           in_position,
	input  logic signed [31:0]   in_value,
	output logic                 res_valid,
	input  logic                 res_take,
	output oal_pkg::oal_result_t res,
	output logic                 mem_re,
	output logic [AW-1:0]        mem_raddr,
	input  logic [31:0]          mem_rdata,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [31:0]          mem_wdata
);

	import oal_pkg::*;

	localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS     = 4'd1;
	localparam logic [3:0] S_INS_PUT = 4'd2;
	localparam logic [3:0] S_DEL     = 4'd3;
	localparam logic [3:0] S_DEL_CLR = 4'd4;
	localparam logic [3:0] S_GET     = 4'd5;
	localparam logic [3:0] S_WAIT    = 4'd6;
	localparam logic [3:0] S_LOC     = 4'd7;
	localparam logic [3:0] S_LOC_END = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	logic [3:0]          state_q;
	logic [DATA_W-1:0]   val_q;
	logic [AW-1:0]       p0_q;
	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       rd_idx_q;
	logic                first_q;
	logic [STAT_W-1:0]   status_q;
	logic [DATA_W-1:0]   data_q;
	logic [POS_W-1:0]    found_q;

	logic                mv_s1;
	logic                cap_s1;
	logic                cmp_s1;
	logic [AW-1:0]       dst_s1;
	logic [AW-1:0]       cidx_s1;

	logic [CMP_W-1:0]    pos_ext;
	logic [CMP_W-1:0]    cnt_ext;
	logic                ins_bad;
	logic                acc_bad;
	logic                full;
	logic [AW-1:0]       in_p0;
	logic [AW-1:0]       last_idx;
	logic                hit;
	logic                busy_s1;
	logic [POS_W-1:0]    hit_pos;

	assign pos_ext  = CMP_W'(in_position);
	assign cnt_ext  = CMP_W'(cnt_q);
	assign ins_bad  = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));
	assign acc_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);
	assign full     = (cnt_q == CW'(CAPACITY));
	assign in_p0    = AW'(pos_ext - CMP_W'(1));
	assign last_idx = AW'(cnt_q - CW'(1));
	assign hit      = cmp_s1 && (mem_rdata == val_q);
	assign busy_s1  = mv_s1 || cap_s1 || cmp_s1;
	assign hit_pos  = POS_W'(CW'(cidx_s1) + CW'(1));

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	assign res.status         = status_q;
	assign res.data_out       = data_q;
	assign res.found_position = found_q;
	assign res.count          = POS_W'(cnt_q);
	assign res.is_empty       = (cnt_q == '0);

	// read issue
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = rd_idx_q;
		case (state_q)
			S_INS, S_DEL, S_GET: mem_re = 1'b1;
			S_LOC: mem_re = !hit;
			default: mem_re = 1'b0;
		endcase
	end

	// write: pending move beats win over direct writes
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = dst_s1;
		mem_wdata = mem_rdata;
		if (mv_s1) begin
			mem_we = 1'b1;
		end else if (state_q == S_INS_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = p0_q;
			mem_wdata = val_q;
		end else if (state_q == S_DEL_CLR && !busy_s1) begin
			mem_we    = 1'b1;
			mem_waddr = last_idx;
			mem_wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1  <= 1'b0;
			cap_s1 <= 1'b0;
			cmp_s1 <= 1'b0;
		end else begin
			mv_s1  <= (state_q == S_INS) || (state_q == S_DEL && !first_q);
			cap_s1 <= (state_q == S_DEL && first_q) || (state_q == S_GET);
			cmp_s1 <= (state_q == S_LOC) && !hit;
		end
	end

	always_ff @(posedge clk) begin
		dst_s1  <= (state_q == S_INS) ? AW'(rd_idx_q + AW'(1)) : AW'(rd_idx_q - AW'(1));
		cidx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			val_q    <= '0;
			p0_q     <= '0;
			rd_idx_q <= '0;
			first_q  <= 1'b0;
			status_q <= ST_OK;
			data_q   <= '0;
			found_q  <= '0;
		end else begin
			if (cap_s1) begin
				data_q <= mem_rdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						val_q    <= in_value;
						p0_q     <= in_p0;
						data_q   <= '0;
						found_q  <= '0;
						status_q <= ST_OK;
						first_q  <= 1'b1;
						unique case (in_mode)
							OP_INSERT: begin
								if (ins_bad) begin
									status_q <= ST_BADPOS;
									state_q  <= S_DONE;
								end else if (full) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else if (pos_ext == cnt_ext + CMP_W'(1)) begin
									state_q <= S_INS_PUT;
								end else begin
									rd_idx_q <= last_idx;
									state_q  <= S_INS;
								end
							end
							OP_DELETE: begin
								if (acc_bad) begin
									status_q <= ST_BADPOS;
									state_q  <= S_DONE;
								end else begin
									rd_idx_q <= in_p0;
									state_q  <= S_DEL;
								end
							end
							OP_LOCATE: begin
								if (cnt_q == '0) begin
									status_q <= ST_NOTFOUND;
									state_q  <= S_DONE;
								end else begin
									rd_idx_q <= '0;
									state_q  <= S_LOC;
								end
							end
							OP_GET: begin
								if (acc_bad) begin
									status_q <= ST_BADPOS;
									state_q  <= S_DONE;
								end else begin
									rd_idx_q <= in_p0;
									state_q  <= S_GET;
								end
							end
						endcase
					end
				end
				S_INS: begin
					if (rd_idx_q == p0_q) begin
						state_q <= S_INS_PUT;
					end else begin
						rd_idx_q <= rd_idx_q - AW'(1);
					end
				end
				S_INS_PUT: begin
					if (!mv_s1) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_DEL: begin
					first_q <= 1'b0;
					if (rd_idx_q == last_idx) begin
						state_q <= S_DEL_CLR;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				S_DEL_CLR: begin
					if (!busy_s1) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_GET: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!busy_s1) begin
						state_q <= S_DONE;
					end
				end
				S_LOC: begin
					if (hit) begin
						found_q <= hit_pos;
						state_q <= S_DONE;
					end else if (rd_idx_q == last_idx) begin
						state_q <= S_LOC_END;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				S_LOC_END: begin
					if (hit) begin
						found_q <= hit_pos;
					end else begin
						status_q <= ST_NOTFOUND;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/ordered_array_list_engine.sv */
// Top level of the ordered array list engine: sequencer, entry store, result register.
// Depends on oal_pkg, oal_if, oal_mem and oal_ctrl.
//
//   channel  dir  beat contents
//   req      in   mode, position, value
//   rsp      out  status, data_out, found_position, count, is_empty
//
// One request at a time; req.ready is high while the sequencer is idle.
// Insert moves the entries from request position p to the end up by one (an append moves none);
// delete moves the later entries down and clears the last; locate scans from the first entry.
// The single read and single write port of the entry store limit these walks to one entry per cycle.
// Reset clears the count and control state, not the entries; entries need no clearing pass.
// A result waits in the output register while the next request is taken.
module ordered_array_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	oal_req_if.sink   req,
	oal_rsp_if.source rsp
);

	import oal_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	oal_result_t       res;
	oal_result_t       ores_q;
	logic              res_valid;
	logic              out_free;
	logic              ovalid_q;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;

	assign out_free = !ovalid_q || rsp.ready;

	oal_ctrl #(
		.CAPACITY(CAPACITY),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.in_mode(req.mode),
		.in_position(req.position),
		.in_value(req.value),
		.res_valid(res_valid),
		.res_take(out_free),
		.res(res),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata)
	);

	oal_mem #(
		.DEPTH(CAPACITY),
		.AW(AW),
		.DW(DATA_W)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			ores_q <= res;
		end
	end

	assign rsp.valid          = ovalid_q;
	assign rsp.status         = ores_q.status;
	assign rsp.data_out       = ores_q.data_out;
	assign rsp.found_position = ores_q.found_position;
	assign rsp.count          = ores_q.count;
	assign rsp.is_empty       = ores_q.is_empty;

	a_empty_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.is_empty == (rsp.count == '0)))
		else $error("is_empty disagrees with count");

	a_found_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found_position != '0) |-> (rsp.status == ST_OK))
		else $error("found position reported on a failed request");

	a_no_data_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.data_out == '0))
		else $error("data returned on a failed request");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while previous one in flight");

endmodule
